// ----- rtl/pms_pkg.sv -----
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types, constants and helpers for the projectile motion step block.
// ----------------------------------------------------------------------------
package pms_pkg;

  // fixed point formats
  localparam int FRAC_BITS      = 16;
  localparam int DT_FRAC        = 16;
  localparam int HOME_MIN_UNITS = 10;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SPEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFESPAN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DESTROY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_ENABLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_ACCEL  = 3'd6;

  // configuration reset values
  localparam logic signed [31:0] GRAVITY_RST       = -32'sd642252;
  localparam logic [30:0]        INITIAL_SPEED_RST = 31'd196608;

  typedef struct packed {
    logic               func;
    logic [15:0]        delta_t;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic               target_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic               hide_owner;
    logic               is_active;
  } out_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD_FIRE,
    OP_LOAD_HOME,
    OP_LOAD_VEL,
    OP_MUL_SQ,
    OP_ADD_SS,
    OP_MUL_MAXSQ,
    OP_SQRT_START,
    OP_MUL_SCALE,
    OP_DIV_START,
    OP_WR_ACC,
    OP_WR_VEL,
    OP_VEL_ZERO,
    OP_FIRE_SET,
    OP_LT_ADD,
    OP_SET_HIDE,
    OP_DEACT,
    OP_MUL_GRAV,
    OP_MUL_ACC,
    OP_ADD_VEL,
    OP_MUL_VEL,
    OP_WR_DELTA,
    OP_OUT_LOAD
  } op_e;

  // magnitude used by a rescale
  typedef enum logic [1:0] {
    SC_INIT,
    SC_HOME,
    SC_MAX
  } scale_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
    scale_e     sel;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic target_valid;
    logic active;
    logic lifespan_nz;
    logic auto_destroy;
    logic home_en;
    logic max_nz;
    logic lt_ended;
    logic ss_zero;
    logic ss_ge_min;
    logic ss_gt_prod;
    logic sqrt_busy;
    logic div_busy;
  } status_t;

  // magnitude of a signed word
  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : 32'(x);
    return r;
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat34(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/projectile_motion_step_top.sv -----
// ----------------------------------------------------------------------------
// projectile_motion_step_top
// Fixed point projectile integrator with fire, lifespan, homing and speed cap.
// ----------------------------------------------------------------------------
// Each rescale (fire, homing, speed cap) runs the shared 1-bit-per-cycle square
// root once and the shared divider once per component, three runs; an inactive
// tick skips all arithmetic, and the speed cap compare comes before its rescale.
// Throughput: one transaction at a time; a finished result waits in the
// output register while the next transaction is already being worked on.
// Reset: asynchronous, active low; state cleared, projectile active, registers
// at their defaults.
module projectile_motion_step_top #(
  parameter int FRAC_BITS = pms_pkg::FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pms_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pms_pkg::out_t                 out_data_o
);

  pms_pkg::cmd_t    cmd;
  pms_pkg::status_t status;

  // sequencer
  pms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  pms_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  // no new transaction while an iterative unit is running
  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!status.sqrt_busy && !status.div_busy))
    else $error("iterative unit busy while idle");

  // divide starts only with a settled length
  a_div_after_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == pms_pkg::OP_DIV_START) |-> !status.sqrt_busy)
    else $error("divide started during square root");

  // accepting a transaction leaves idle
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer stayed idle after accept");

  // hidden owner keeps the projectile active with no motion
  a_hide_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.hide_owner) |->
      (out_data_o.is_active && out_data_o.delta_x == 32'sd0 &&
       out_data_o.delta_y == 32'sd0 && out_data_o.delta_z == 32'sd0))
    else $error("hide result with motion or inactive");

endmodule

// ----- rtl/pms_sqrt.sv -----
// ----------------------------------------------------------------------------
// pms_sqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module pms_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic        busy_q;
  logic [4:0]  k_q;
  logic [63:0] rem_q;
  logic [63:0] res_q;
  logic [63:0] bit_w;
  logic [63:0] trial;
  logic        ge;

  // trial subtraction for the current bit pair
  always_comb begin
    bit_w = 64'(1) << {k_q, 1'b0};
    trial = res_q + bit_w;
    ge    = rem_q >= trial;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      k_q    <= 5'd31;
    end else if (busy_q) begin
      if (k_q == 5'd0) begin
        busy_q <= 1'b0;
      end else begin
        k_q <= k_q - 5'd1;
      end
    end
  end

  // remainder and root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= radicand_i;
      res_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_w;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[31:0];

endmodule

// ----- rtl/pms_div.sv -----
// ----------------------------------------------------------------------------
// pms_div
// Restoring 64 by 32 bit divider with 32-bit quotient and overflow flag.
// ----------------------------------------------------------------------------
module pms_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o,
  output logic        ovf_o
);

  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic        ovf_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic        ovf_d;

  // one restoring step
  always_comb begin
    trial = {rem_q, quo_q[31]};
    ge    = trial >= {1'b0, divisor_i};
    diff  = trial - {1'b0, divisor_i};
    ovf_d = dividend_i[63:32] >= divisor_i;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !ovf_d;
      cnt_q  <= 5'd31;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= ovf_d;
      rem_q <= dividend_i[63:32];
      quo_q <= dividend_i[31:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
  assign ovf_o  = ovf_q;

endmodule

// ----- rtl/pms_dp.sv -----
// ----------------------------------------------------------------------------
// pms_dp
// Datapath: configuration, projectile state, shared multiplier, sqrt, divider.
// ----------------------------------------------------------------------------
module pms_dp #(
  parameter int FRAC_BITS = pms_pkg::FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  pms_pkg::in_t                   in_data_i,
  input  pms_pkg::cmd_t                  cmd_i,
  output pms_pkg::status_t               status_o,
  output pms_pkg::out_t                  out_data_o
);

  localparam int LSH = (FRAC_BITS >= pms_pkg::DT_FRAC) ? FRAC_BITS - pms_pkg::DT_FRAC : 0;
  localparam int RSH = (FRAC_BITS < pms_pkg::DT_FRAC) ? pms_pkg::DT_FRAC - FRAC_BITS : 0;
  localparam int RND = (1 << RSH) >> 1;
  localparam logic [63:0] MIN_LEN = 64'(pms_pkg::HOME_MIN_UNITS) << FRAC_BITS;
  localparam logic [63:0] MIN_SQ  = MIN_LEN * MIN_LEN;

  // configuration
  logic signed [31:0] gravity_q;
  logic [30:0]        initial_speed_q;
  logic [30:0]        max_speed_q;
  logic [30:0]        lifespan_q;
  logic               auto_destroy_q;
  logic               homing_enable_q;
  logic [30:0]        homing_accel_q;

  // projectile state
  logic signed [31:0] vel_q [3];
  logic signed [31:0] acc_q [3];
  logic [31:0]        lifetime_q;
  logic               active_q;

  // working registers
  pms_pkg::in_t       in_q;
  pms_pkg::out_t      out_q;
  logic signed [31:0] c_q [3];
  logic signed [31:0] d_q [3];
  logic               hide_q;
  logic [63:0]        ss_q;
  logic [63:0]        prod_q;
  logic               neg_q;

  logic signed [31:0] vec [3];
  logic signed [31:0] pos [3];
  logic signed [31:0] home_c [3];
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic               mul_neg;
  logic [63:0]        prod_d;
  logic [32:0]        rnd_mag;
  logic signed [33:0] rnd_s;
  logic signed [33:0] vel_sum;
  logic signed [31:0] scaled;
  logic               big;
  logic [32:0]        lt_add;
  logic [32:0]        lt_sum;
  logic [31:0]        root;
  logic [31:0]        quot;
  logic               ovf;
  logic               sqrt_busy;
  logic               div_busy;
  logic [1:0]         idx;

  assign idx = cmd_i.idx;

  // input fields as vectors
  always_comb begin
    vec[0] = in_q.vec_x;
    vec[1] = in_q.vec_y;
    vec[2] = in_q.vec_z;
    pos[0] = in_q.pos_x;
    pos[1] = in_q.pos_y;
    pos[2] = in_q.pos_z;
    for (int i = 0; i < 3; i++) begin
      home_c[i] = pms_pkg::sat34(34'(vec[i]) - 34'(pos[i]));
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (cmd_i.op)
      pms_pkg::OP_MUL_SQ: begin
        mul_a = pms_pkg::abs32(c_q[idx]);
        mul_b = mul_a;
      end
      pms_pkg::OP_MUL_MAXSQ: begin
        mul_a = {1'b0, max_speed_q};
        mul_b = mul_a;
      end
      pms_pkg::OP_MUL_SCALE: begin
        mul_a   = pms_pkg::abs32(c_q[idx]);
        mul_neg = c_q[idx][31];
        case (cmd_i.sel)
          pms_pkg::SC_INIT: mul_b = {1'b0, initial_speed_q};
          pms_pkg::SC_HOME: mul_b = {1'b0, homing_accel_q};
          pms_pkg::SC_MAX:  mul_b = {1'b0, max_speed_q};
          default:          mul_b = '0;
        endcase
      end
      pms_pkg::OP_MUL_GRAV: begin
        mul_a   = pms_pkg::abs32(gravity_q);
        mul_b   = 32'(in_q.delta_t);
        mul_neg = gravity_q[31];
      end
      pms_pkg::OP_MUL_ACC: begin
        mul_a   = pms_pkg::abs32(acc_q[idx]);
        mul_b   = 32'(in_q.delta_t);
        mul_neg = acc_q[idx][31];
      end
      pms_pkg::OP_MUL_VEL: begin
        mul_a   = pms_pkg::abs32(vel_q[idx]);
        mul_b   = 32'(in_q.delta_t);
        mul_neg = vel_q[idx][31];
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  // rounding of time products, velocity add, rescale result, lifetime add
  always_comb begin
    rnd_mag = 33'((prod_q + (64'(1) << (pms_pkg::DT_FRAC - 1))) >> pms_pkg::DT_FRAC);
    rnd_s   = neg_q ? -34'(rnd_mag) : 34'(rnd_mag);
    vel_sum = 34'(vel_q[idx]) + rnd_s;
    big     = ovf | quot[31];
    if (neg_q) begin
      scaled = big ? 32'sh80000000 : -$signed(quot);
    end else begin
      scaled = big ? 32'sh7FFFFFFF : $signed(quot);
    end
    lt_add = ((33'(in_q.delta_t) << LSH) + 33'(RND)) >> RSH;
    lt_sum = {1'b0, lifetime_q} + lt_add;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q       <= pms_pkg::GRAVITY_RST;
      initial_speed_q <= pms_pkg::INITIAL_SPEED_RST;
      max_speed_q     <= '0;
      lifespan_q      <= '0;
      auto_destroy_q  <= 1'b0;
      homing_enable_q <= 1'b0;
      homing_accel_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pms_pkg::CFG_GRAVITY:       gravity_q       <= $signed(cfg_data_i);
        pms_pkg::CFG_INITIAL_SPEED: initial_speed_q <= cfg_data_i[30:0];
        pms_pkg::CFG_MAX_SPEED:     max_speed_q     <= cfg_data_i[30:0];
        pms_pkg::CFG_LIFESPAN:      lifespan_q      <= cfg_data_i[30:0];
        pms_pkg::CFG_AUTO_DESTROY:  auto_destroy_q  <= cfg_data_i[0];
        pms_pkg::CFG_HOMING_ENABLE: homing_enable_q <= cfg_data_i[0];
        pms_pkg::CFG_HOMING_ACCEL:  homing_accel_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // projectile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
      lifetime_q <= '0;
      active_q   <= 1'b1;
    end else begin
      case (cmd_i.op)
        pms_pkg::OP_WR_ACC:   acc_q[idx] <= scaled;
        pms_pkg::OP_WR_VEL:   vel_q[idx] <= scaled;
        pms_pkg::OP_ADD_VEL:  vel_q[idx] <= pms_pkg::sat34(vel_sum);
        pms_pkg::OP_VEL_ZERO: begin
          for (int i = 0; i < 3; i++) begin
            vel_q[i] <= '0;
          end
        end
        pms_pkg::OP_FIRE_SET: begin
          active_q   <= 1'b1;
          lifetime_q <= '0;
        end
        pms_pkg::OP_LT_ADD:   lifetime_q <= lt_sum[32] ? 32'hFFFFFFFF : lt_sum[31:0];
        pms_pkg::OP_DEACT:    active_q <= 1'b0;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == pms_pkg::OP_MUL_SQ || cmd_i.op == pms_pkg::OP_MUL_MAXSQ ||
        cmd_i.op == pms_pkg::OP_MUL_SCALE || cmd_i.op == pms_pkg::OP_MUL_GRAV ||
        cmd_i.op == pms_pkg::OP_MUL_ACC || cmd_i.op == pms_pkg::OP_MUL_VEL) begin
      prod_q <= prod_d;
      neg_q  <= mul_neg;
    end
    case (cmd_i.op)
      pms_pkg::OP_LATCH: begin
        in_q   <= in_data_i;
        hide_q <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= '0;
        end
      end
      pms_pkg::OP_LOAD_FIRE: begin
        ss_q <= '0;
        for (int i = 0; i < 3; i++) begin
          c_q[i] <= vec[i];
        end
      end
      pms_pkg::OP_LOAD_HOME: begin
        ss_q <= '0;
        for (int i = 0; i < 3; i++) begin
          c_q[i] <= home_c[i];
        end
      end
      pms_pkg::OP_LOAD_VEL: begin
        ss_q <= '0;
        for (int i = 0; i < 3; i++) begin
          c_q[i] <= vel_q[i];
        end
      end
      pms_pkg::OP_ADD_SS:   ss_q <= ss_q + prod_q;
      pms_pkg::OP_SET_HIDE: hide_q <= 1'b1;
      pms_pkg::OP_WR_DELTA: d_q[idx] <= pms_pkg::sat34(rnd_s);
      pms_pkg::OP_OUT_LOAD: begin
        out_q.delta_x    <= d_q[0];
        out_q.delta_y    <= d_q[1];
        out_q.delta_z    <= d_q[2];
        out_q.hide_owner <= hide_q;
        out_q.is_active  <= active_q;
      end
      default: ;
    endcase
  end

  // shared iterative units
  pms_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == pms_pkg::OP_SQRT_START),
    .radicand_i (ss_q),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  pms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == pms_pkg::OP_DIV_START),
    .dividend_i (prod_q),
    .divisor_i  (root),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .ovf_o      (ovf)
  );

  // status to the controller
  always_comb begin
    status_o.func         = in_q.func;
    status_o.target_valid = in_q.target_valid;
    status_o.active       = active_q;
    status_o.lifespan_nz  = lifespan_q != '0;
    status_o.auto_destroy = auto_destroy_q;
    status_o.home_en      = homing_enable_q && (homing_accel_q != '0);
    status_o.max_nz       = max_speed_q != '0;
    status_o.lt_ended     = lifetime_q >= {1'b0, lifespan_q};
    status_o.ss_zero      = ss_q == '0;
    status_o.ss_ge_min    = ss_q >= MIN_SQ;
    status_o.ss_gt_prod   = ss_q > prod_q;
    status_o.sqrt_busy    = sqrt_busy;
    status_o.div_busy     = div_busy;
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/pms_ctrl.sv -----
// ----------------------------------------------------------------------------
// pms_ctrl
// Sequencer: steps the datapath through fire and tick operations.
// ----------------------------------------------------------------------------
module pms_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pms_pkg::status_t status_i,
  output pms_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_LT_CHK,
    ST_HOME_CHK,
    ST_SS_MUL,
    ST_SS_ADD,
    ST_SS_DEC,
    ST_LIM_CMP,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_SC_MUL,
    ST_SC_DIV,
    ST_SC_WAIT,
    ST_SC_WR,
    ST_FIRE_FIN,
    ST_GRAV_MUL,
    ST_GRAV_ADD,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_LIM_LOAD,
    ST_DL_MUL,
    ST_DL_WR,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    TAG_FIRE,
    TAG_HOME,
    TAG_LIM
  } tag_e;

  state_e     state_q, state_d;
  tag_e       tag_q, tag_d;
  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    tag_d       = tag_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = pms_pkg::OP_NONE;
    cmd_o.idx   = idx_q;
    case (tag_q)
      TAG_FIRE: cmd_o.sel = pms_pkg::SC_INIT;
      TAG_HOME: cmd_o.sel = pms_pkg::SC_HOME;
      default:  cmd_o.sel = pms_pkg::SC_MAX;
    endcase
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = pms_pkg::OP_LATCH;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        idx_d = '0;
        if (status_i.func) begin
          cmd_o.op = pms_pkg::OP_LOAD_FIRE;
          tag_d    = TAG_FIRE;
          state_d  = ST_SS_MUL;
        end else if (!status_i.active) begin
          state_d = ST_DONE;
        end else if (status_i.lifespan_nz) begin
          cmd_o.op = pms_pkg::OP_LT_ADD;
          state_d  = ST_LT_CHK;
        end else begin
          state_d = ST_HOME_CHK;
        end
      end
      ST_LT_CHK: begin
        if (status_i.lt_ended) begin
          cmd_o.op = status_i.auto_destroy ? pms_pkg::OP_SET_HIDE : pms_pkg::OP_DEACT;
          state_d  = ST_DONE;
        end else begin
          state_d = ST_HOME_CHK;
        end
      end
      ST_HOME_CHK: begin
        if (status_i.home_en && status_i.target_valid) begin
          cmd_o.op = pms_pkg::OP_LOAD_HOME;
          tag_d    = TAG_HOME;
          state_d  = ST_SS_MUL;
        end else begin
          state_d = ST_GRAV_MUL;
        end
      end
      // sum of squares over the three components
      ST_SS_MUL: begin
        cmd_o.op = pms_pkg::OP_MUL_SQ;
        state_d  = ST_SS_ADD;
      end
      ST_SS_ADD: begin
        cmd_o.op = pms_pkg::OP_ADD_SS;
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_SS_DEC;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_SS_MUL;
        end
      end
      ST_SS_DEC: begin
        case (tag_q)
          TAG_FIRE: begin
            if (status_i.ss_zero) begin
              cmd_o.op = pms_pkg::OP_VEL_ZERO;
              state_d  = ST_FIRE_FIN;
            end else begin
              state_d = ST_SQRT;
            end
          end
          TAG_HOME: state_d = status_i.ss_ge_min ? ST_SQRT : ST_GRAV_MUL;
          default: begin
            cmd_o.op = pms_pkg::OP_MUL_MAXSQ;
            state_d  = ST_LIM_CMP;
          end
        endcase
      end
      ST_LIM_CMP: begin
        state_d = status_i.ss_gt_prod ? ST_SQRT : ST_DL_MUL;
      end
      // length, then one divide per component
      ST_SQRT: begin
        cmd_o.op = pms_pkg::OP_SQRT_START;
        state_d  = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (!status_i.sqrt_busy) begin
          state_d = ST_SC_MUL;
        end
      end
      ST_SC_MUL: begin
        cmd_o.op = pms_pkg::OP_MUL_SCALE;
        state_d  = ST_SC_DIV;
      end
      ST_SC_DIV: begin
        cmd_o.op = pms_pkg::OP_DIV_START;
        state_d  = ST_SC_WAIT;
      end
      ST_SC_WAIT: begin
        if (!status_i.div_busy) begin
          state_d = ST_SC_WR;
        end
      end
      ST_SC_WR: begin
        cmd_o.op = (tag_q == TAG_HOME) ? pms_pkg::OP_WR_ACC : pms_pkg::OP_WR_VEL;
        if (idx_q == 2'd2) begin
          idx_d = '0;
          case (tag_q)
            TAG_FIRE: state_d = ST_FIRE_FIN;
            TAG_HOME: state_d = ST_GRAV_MUL;
            default:  state_d = ST_DL_MUL;
          endcase
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_SC_MUL;
        end
      end
      ST_FIRE_FIN: begin
        cmd_o.op = pms_pkg::OP_FIRE_SET;
        state_d  = ST_DONE;
      end
      // gravity on z, then acceleration on every axis
      ST_GRAV_MUL: begin
        cmd_o.op = pms_pkg::OP_MUL_GRAV;
        state_d  = ST_GRAV_ADD;
      end
      ST_GRAV_ADD: begin
        cmd_o.op  = pms_pkg::OP_ADD_VEL;
        cmd_o.idx = 2'd2;
        state_d   = ST_ACC_MUL;
      end
      ST_ACC_MUL: begin
        cmd_o.op = pms_pkg::OP_MUL_ACC;
        state_d  = ST_ACC_ADD;
      end
      ST_ACC_ADD: begin
        cmd_o.op = pms_pkg::OP_ADD_VEL;
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = status_i.max_nz ? ST_LIM_LOAD : ST_DL_MUL;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_ACC_MUL;
        end
      end
      ST_LIM_LOAD: begin
        cmd_o.op = pms_pkg::OP_LOAD_VEL;
        tag_d    = TAG_LIM;
        state_d  = ST_SS_MUL;
      end
      // position delta
      ST_DL_MUL: begin
        cmd_o.op = pms_pkg::OP_MUL_VEL;
        state_d  = ST_DL_WR;
      end
      ST_DL_WR: begin
        cmd_o.op = pms_pkg::OP_WR_DELTA;
        if (idx_q == 2'd2) begin
          idx_d   = '0;
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_DL_MUL;
        end
      end
      // hand the result to the output register
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = pms_pkg::OP_OUT_LOAD;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tag_q       <= TAG_FIRE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tag_q       <= tag_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ----- verif/projectile_motion_step_checker.sv -----
// ----------------------------------------------------------------------------
// projectile_motion_step_checker
// Watches the configuration port and both channels of the projectile motion
// step block, predicts every result from its own copy of the projectile state
// and compares each output transaction field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module projectile_motion_step_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  pms_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  pms_pkg::out_t                 out_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);

  localparam logic FUNC_FIRE = 1'b1;
  localparam longint unsigned HOME_MIN_LEN =
    longint'(pms_pkg::HOME_MIN_UNITS) << pms_pkg::FRAC_BITS;

  // register copies
  int               grav;
  logic [30:0]      init_spd;
  logic [30:0]      max_spd;
  logic [30:0]      life_lim;
  logic             auto_dest;
  logic             home_en;
  logic [30:0]      home_acc;

  // projectile state
  int               vel [3];
  int               acc [3];
  logic [31:0]      life_cnt;
  logic             alive;

  pms_pkg::out_t    exp_deltas_q [$];

  function automatic int sat_word(input longint signed x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  // shift right by the delta_t fraction, nearest, ties away from zero
  function automatic longint signed round_dt(input longint signed x);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : longint'(x);
    m = (m + (64'd1 << (pms_pkg::DT_FRAC - 1))) >> pms_pkg::DT_FRAC;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned len_sq(input longint signed a, input longint signed b,
                                             input longint signed c);
    longint unsigned ma, mb, mc;
    ma = (a < 0) ? longint'(-a) : longint'(a);
    mb = (b < 0) ? longint'(-b) : longint'(b);
    mc = (c < 0) ? longint'(-c) : longint'(c);
    return ma * ma + mb * mb + mc * mc;
  endfunction

  // one component of a vector brought to length mag
  function automatic int scale_comp(input longint signed c, input longint unsigned mag,
                                    input longint unsigned len);
    longint unsigned m;
    longint unsigned q;
    m = (c < 0) ? longint'(-c) : longint'(c);
    q = (m * mag) / len;
    if (q > 64'h80000000) q = 64'h80000000;
    return sat_word((c < 0) ? -longint'(q) : longint'(q));
  endfunction

  // advance the projectile by one transaction and return its result
  function automatic pms_pkg::out_t advance_projectile(input pms_pkg::in_t it);
    longint signed   v [3];
    longint signed   c [3];
    longint signed   dtl;
    longint unsigned ss;
    longint unsigned lt;
    longint unsigned ln;
    logic            ended;
    int              d [3];
    pms_pkg::out_t   r;
    r = '0;
    d = '{0, 0, 0};
    dtl = longint'(it.delta_t);
    v[0] = it.vec_x;
    v[1] = it.vec_y;
    v[2] = it.vec_z;
    if (it.func == FUNC_FIRE) begin
      ss = len_sq(v[0], v[1], v[2]);
      if (ss == 0) begin
        vel = '{0, 0, 0};
      end else begin
        ln = floor_sqrt(ss);
        for (int i = 0; i < 3; i++) vel[i] = scale_comp(v[i], init_spd, ln);
      end
      alive = 1'b1;
      life_cnt = '0;
    end else if (alive) begin
      ended = 1'b0;
      // lifetime runs only with a lifespan set
      if (life_lim != 0) begin
        lt = longint'(life_cnt) + longint'(it.delta_t);
        life_cnt = (lt > 64'hFFFFFFFF) ? 32'hFFFFFFFF : lt[31:0];
        if (life_cnt >= {1'b0, life_lim}) begin
          ended = 1'b1;
          if (auto_dest) r.hide_owner = 1'b1;
          else alive = 1'b0;
        end
      end
      if (!ended) begin
        // steer toward a far enough target
        if (home_en && home_acc != 0 && it.target_valid) begin
          c[0] = sat_word(v[0] - longint'(it.pos_x));
          c[1] = sat_word(v[1] - longint'(it.pos_y));
          c[2] = sat_word(v[2] - longint'(it.pos_z));
          ss = len_sq(c[0], c[1], c[2]);
          if (ss >= HOME_MIN_LEN * HOME_MIN_LEN) begin
            ln = floor_sqrt(ss);
            for (int i = 0; i < 3; i++) acc[i] = scale_comp(c[i], home_acc, ln);
          end
        end
        vel[2] = sat_word(longint'(vel[2]) + round_dt(longint'(grav) * dtl));
        for (int i = 0; i < 3; i++)
          vel[i] = sat_word(longint'(vel[i]) + round_dt(longint'(acc[i]) * dtl));
        // speed cap
        if (max_spd != 0) begin
          ss = len_sq(vel[0], vel[1], vel[2]);
          if (ss > longint'(max_spd) * longint'(max_spd)) begin
            ln = floor_sqrt(ss);
            for (int i = 0; i < 3; i++) c[i] = vel[i];
            for (int i = 0; i < 3; i++) vel[i] = scale_comp(c[i], max_spd, ln);
          end
        end
        for (int i = 0; i < 3; i++) d[i] = sat_word(round_dt(longint'(vel[i]) * dtl));
      end
    end
    r.delta_x = d[0];
    r.delta_y = d[1];
    r.delta_z = d[2];
    r.is_active = alive;
    return r;
  endfunction

  // register writes, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    pms_pkg::out_t e;
    if (!rst_ni) begin
      grav      = pms_pkg::GRAVITY_RST;
      init_spd  = pms_pkg::INITIAL_SPEED_RST;
      max_spd   = '0;
      life_lim  = '0;
      auto_dest = 1'b0;
      home_en   = 1'b0;
      home_acc  = '0;
      vel       = '{0, 0, 0};
      acc       = '{0, 0, 0};
      life_cnt  = '0;
      alive     = 1'b1;
      exp_deltas_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pms_pkg::CFG_GRAVITY:       grav      = cfg_data_i;
          pms_pkg::CFG_INITIAL_SPEED: init_spd  = cfg_data_i[30:0];
          pms_pkg::CFG_MAX_SPEED:     max_spd   = cfg_data_i[30:0];
          pms_pkg::CFG_LIFESPAN:      life_lim  = cfg_data_i[30:0];
          pms_pkg::CFG_AUTO_DESTROY:  auto_dest = cfg_data_i[0];
          pms_pkg::CFG_HOMING_ENABLE: home_en   = cfg_data_i[0];
          pms_pkg::CFG_HOMING_ACCEL:  home_acc  = cfg_data_i[30:0];
          default: ;
        endcase
      end
      // output transaction against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (exp_deltas_q.size() == 0) begin
          $error("unexpected output transaction");
          fail_cnt_o++;
        end else begin
          e = exp_deltas_q.pop_front();
          if (out_data_i.delta_x !== e.delta_x) begin
            $error("delta_x expected %0d got %0d", e.delta_x, out_data_i.delta_x);
            fail_cnt_o++;
          end
          if (out_data_i.delta_y !== e.delta_y) begin
            $error("delta_y expected %0d got %0d", e.delta_y, out_data_i.delta_y);
            fail_cnt_o++;
          end
          if (out_data_i.delta_z !== e.delta_z) begin
            $error("delta_z expected %0d got %0d", e.delta_z, out_data_i.delta_z);
            fail_cnt_o++;
          end
          if (out_data_i.hide_owner !== e.hide_owner) begin
            $error("hide_owner expected %0d got %0d", e.hide_owner, out_data_i.hide_owner);
            fail_cnt_o++;
          end
          if (out_data_i.is_active !== e.is_active) begin
            $error("is_active expected %0d got %0d", e.is_active, out_data_i.is_active);
            fail_cnt_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) exp_deltas_q.push_back(advance_projectile(in_data_i));
      pending_o = exp_deltas_q.size();
    end
  end

endmodule

// ----- verif/projectile_motion_step_top_tb.sv -----
// ----------------------------------------------------------------------------
// projectile_motion_step_top_tb
// Drives fire and tick transactions through the projectile motion step block
// under several register settings, with random gaps on both channels and one
// long output hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module projectile_motion_step_top_tb;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_FIRE  = 1'b1;
  localparam int   N_PHASES   = 10;
  localparam int   PHASE_LEN  = 165;
  localparam int   HOLD_LEN   = 300;
  localparam int   DRAIN_WAIT = 600;
  localparam int   CYCLE_LIMIT = 4000000;
  localparam int   UNIT = 1 << pms_pkg::FRAC_BITS;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [pms_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]                   cfg_data;
  logic                          in_vld;
  logic                          in_rdy;
  pms_pkg::in_t                  in_dat;
  logic                          out_vld;
  logic                          out_rdy;
  pms_pkg::out_t                 out_dat;
  int                            fail_cnt;
  int                            pending;
  int                            cycle_cnt;
  logic                          hold_req;
  logic                          calm;

  projectile_motion_step_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_vld),
    .in_ready_o (in_rdy),
    .in_data_i  (in_dat),
    .out_valid_o(out_vld),
    .out_ready_i(out_rdy),
    .out_data_o (out_dat)
  );

  projectile_motion_step_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_vld),
    .in_ready_i (in_rdy),
    .in_data_i  (in_dat),
    .out_valid_i(out_vld),
    .out_ready_i(out_rdy),
    .out_data_i (out_dat),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output side: random stalls and one long hold-off on request
  initial begin
    int r;
    int gap;
    out_rdy = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      r = $urandom_range(0, 99);
      if (hold_req) begin
        out_rdy <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || r < 70) begin
        out_rdy <= 1'b1;
      end else begin
        out_rdy <= 1'b0;
        gap = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        repeat (gap - 1) @(posedge clk);
      end
    end
  end

  // offer one transaction and wait for its handshake, then maybe idle
  task automatic send_item(input pms_pkg::in_t it);
    int r;
    in_vld <= 1'b1;
    in_dat <= it;
    do @(posedge clk); while (!in_rdy);
    r = $urandom_range(0, 99);
    if (!calm && r >= 60) begin
      in_vld <= 1'b0;
      repeat ((r < 95) ? $urandom_range(1, 4) : $urandom_range(10, 60)) @(posedge clk);
    end
  endtask

  // wait until every result is back and the block has settled
  task automatic wait_idle();
    in_vld <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // write all seven registers on consecutive edges
  task automatic write_regs(input int g, input int isp, input int msp, input int ls,
                            input int ad, input int he, input int ha);
    int vals [7];
    vals = '{g, isp, msp, ls, ad, he, ha};
    for (int i = 0; i < 7; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= i[pms_pkg::CFG_IDX_W-1:0];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pms_pkg::in_t make_item(input logic fn, input int dt, input int x,
                                             input int y, input int z, input logic tv,
                                             input int px, input int py, input int pz);
    pms_pkg::in_t it;
    it.func = fn;
    it.delta_t = dt[15:0];
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    it.target_valid = tv;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    return it;
  endfunction

  // a coordinate: mostly moderate, sometimes extreme or raw
  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh80000000;
      1: return 32'sh7FFFFFFF;
      2: return 0;
      3, 4: return $urandom();
      default: return int'($urandom_range(0, 2000 * UNIT)) - 1000 * UNIT;
    endcase
  endfunction

  // an unsigned register value: zero, full scale, raw or moderate
  function automatic int pick_mag(input int moderate);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'h7FFFFFFF;
      2: return $urandom();
      default: return $urandom_range(1, moderate);
    endcase
  endfunction

  function automatic int pick_dt();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16'hFFFF;
      2, 3: return $urandom_range(0, 16'hFFFF);
      default: return $urandom_range(256, 4096);
    endcase
  endfunction

  // random item: mostly ticks with a target near the projectile
  function automatic pms_pkg::in_t rand_item();
    int px, py, pz;
    int off;
    px = pick_coord();
    py = pick_coord();
    pz = pick_coord();
    if ($urandom_range(0, 9) == 0)
      return make_item(FUNC_FIRE, $urandom(), pick_coord(), pick_coord(), pick_coord(),
                       $urandom_range(0, 1), px, py, pz);
    off = ($urandom_range(0, 3) == 0) ? 8 * UNIT : 200 * UNIT;
    if ($urandom_range(0, 3) == 0)
      return make_item(FUNC_TICK, pick_dt(), pick_coord(), pick_coord(), pick_coord(),
                       $urandom_range(0, 1), px, py, pz);
    return make_item(FUNC_TICK, pick_dt(),
                     px + int'($urandom_range(0, 2 * off)) - off,
                     py + int'($urandom_range(0, 2 * off)) - off,
                     pz + int'($urandom_range(0, 2 * off)) - off,
                     $urandom_range(0, 4) != 0, px, py, pz);
  endfunction

  // stimulus
  initial begin
    int g;
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    in_vld   = 1'b0;
    in_dat   = '0;
    hold_req = 1'b0;
    calm     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: zero fire, plain ticks
    send_item(make_item(FUNC_TICK, 16'hFFFF, 0, 0, 0, 1'b1, 0, 0, 0));
    send_item(make_item(FUNC_FIRE, 0, 0, 0, 0, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 0, 0, 0, 0, 1'b0, 0, 0, 0));
    wait_idle();

    // homing at full strength, extreme directions and targets
    write_regs(-642252, 32'h7FFFFFFF, 0, 0, 0, 1, 32'h7FFFFFFF);
    send_item(make_item(FUNC_FIRE, 0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1'b1,
                        0, 0, 0));
    send_item(make_item(FUNC_TICK, 16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                        1'b1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000));
    send_item(make_item(FUNC_TICK, 4096, 5 * UNIT, 0, 0, 1'b1, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 4096, 10 * UNIT, 0, 0, 1'b1, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 4096, 50 * UNIT, 0, 0, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_FIRE, 0, 0, 0, 0, 1'b1, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 16'hFFFF, 0, 0, 0, 1'b0, 0, 0, 0));
    wait_idle();

    // speed cap, auto destroy at end of life, strongest downward gravity
    write_regs(32'sh80000000, 100 * UNIT, 20 * UNIT, UNIT, 1, 0, 5 * UNIT);
    send_item(make_item(FUNC_FIRE, 0, UNIT, UNIT, UNIT, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32768, 0, 0, 0, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 32768, 0, 0, 0, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 100, 0, 0, 0, 1'b0, 0, 0, 0));
    wait_idle();

    // end of life deactivates, inactive ticks, fire revives
    write_regs(32'sh7FFFFFFF, 0, 32'h7FFFFFFF, 1, 0, 1, 0);
    send_item(make_item(FUNC_FIRE, 0, 3 * UNIT, -4 * UNIT, 0, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 0, 0, 0, 0, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 1, 0, 0, 0, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 16'hFFFF, 0, 0, 0, 1'b1, 0, 0, 0));
    send_item(make_item(FUNC_FIRE, 0, 0, 0, -UNIT, 1'b0, 0, 0, 0));
    send_item(make_item(FUNC_TICK, 16'hFFFF, 0, 0, 0, 1'b0, 0, 0, 0));
    wait_idle();

    // random phases, each under a fresh register setting
    for (int p = 0; p < N_PHASES; p++) begin
      g = ($urandom_range(0, 3) == 0) ? $urandom()
                                      : int'($urandom_range(0, 40 * UNIT)) - 20 * UNIT;
      write_regs(g, pick_mag(200 * UNIT), pick_mag(400 * UNIT),
                 ($urandom_range(0, 2) == 0) ? 0 : pick_mag(2000 * UNIT),
                 $urandom(), ($urandom_range(0, 3) != 0) | ($urandom() & 32'hFFFFFFFE),
                 pick_mag(50 * UNIT));
      calm = (p % 4 == 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 3 && n == 20) hold_req = 1'b1;
        send_item(rand_item());
      end
      wait_idle();
    end
    calm = 1'b0;

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
